// ----- hw/rtl/ebss_pkg.sv -----
// package: types, codes and constants of the encoder button slot selector
`timescale 1ns / 1ps

package ebss_pkg;

  localparam int SlotCountDef = 8;

  localparam int CountW   = 32;
  localparam int TimeW    = 32;
  localparam int HoldW    = 16;
  localparam int DblW     = 16;
  localparam int DivW     = 7;
  localparam int TmoW     = 24;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;
  localparam int DivCntW  = $clog2(CountW);

  localparam logic [HoldW-1:0] HoldRst = HoldW'(500);
  localparam logic [DblW-1:0]  DblRst  = DblW'(250);
  localparam logic [DivW-1:0]  DivRst  = DivW'(8);
  localparam logic [TmoW-1:0]  TmoRst  = TmoW'(30500);
  localparam logic [DivW-1:0]  DivFine = DivW'(4);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOLD    = 2'd0,
    CFG_DOUBLE  = 2'd1,
    CFG_DIVIDER = 2'd2,
    CFG_TIMEOUT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_IDLE     = 3'd0,
    EV_PRESSED  = 3'd1,
    EV_HELD     = 3'd2,
    EV_RELEASED = 3'd3,
    EV_DOUBLE   = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPDATE
  } state_e;

endpackage

// ----- hw/rtl/encoder_button_slot_selector_top.sv -----
// top level: button classifier, serial detent divider and slot preview logic
`timescale 1ns / 1ps

// Usage
// Input channel: in_valid_i / in_stall_o with button_level_i, encoder_count_i
// and now_ms_i, one item per poll. Output channel: out_valid_o / out_stall_i
// with one result item for every input item, in order.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high, write only while no item is in flight.
// Sequence: an accepted item passes through the restoring divider (one
// quotient bit per cycle through one 8-bit compare and subtract), then the
// update state, which writes its result to the output register. No new item
// is taken while one is in the divider or the update state; the next item is
// accepted in the cycle after the update, while the result may still wait in the output register.
// A stalled output holds its item; the update cycle waits until the output
// register is free, and the input stays stalled meanwhile.
// Reset: the configuration returns to its default values, the button counts as
// pressed, all slots are zero and no result is pending.
module encoder_button_slot_selector_top
  import ebss_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       button_level_i,
  input  logic signed [CountW-1:0]   encoder_count_i,
  input  logic        [TimeW-1:0]    now_ms_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic        [2:0]          button_event_o,
  output logic        [1:0]          turn_direction_o,
  output logic signed [CountW-1:0]   step_amount_o,
  output logic signed [CountW-1:0]   turn_position_o,
  output logic        [2:0]          preview_slot_out_o,
  output logic        [2:0]          active_slot_out_o,
  output logic                       slot_committed_o,
  output logic                       preview_showing_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic        [CfgIdxW-1:0]  cfg_index_i,
  input  logic        [CfgDataW-1:0] cfg_data_i
);

  localparam int SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SlotW:0]   SlotCnt  = (SlotW + 1)'(SLOT_COUNT);
  localparam logic [SlotW-1:0] SlotLast = SlotW'(SLOT_COUNT - 1);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(CountW - 1);

  // configuration
  logic [HoldW-1:0] hold_q;
  logic [DblW-1:0]  dbl_q;
  logic [DivW-1:0]  divcfg_q;
  logic [TmoW-1:0]  tmo_q;
  logic             cfg_we;

  // sequencer and divider
  state_e              state_q, state_d;
  logic                in_accept, upd_fire;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [CountW-1:0]   dq_q, dq_d;
  logic [DivW-1:0]     rem_q, rem_d;
  logic [DivW:0]       rem_t;
  logic                rem_ge;
  logic [DivW-1:0]     div_q, div_d;
  logic                neg_q, pressed_q;
  logic [TimeW-1:0]    now_q;
  logic [CountW-1:0]   mag_in;
  logic                load_en, div_en, upd_en;

  // block state
  logic                 was_pressed_q;
  event_e               ev_now_q;
  logic [TimeW-1:0]     press_start_q, last_click_q, pv_start_q;
  logic signed [CountW-1:0] last_detent_q;
  dir_e                 dir_q;
  logic [CountW-1:0]    step_total_q;
  logic [SlotW-1:0]     pv_slot_q, act_slot_q, shown_q;
  logic                 showing_q;
  logic [DivW-1:0]      div_seen_q;

  // update results
  event_e               ev_new;
  logic [TimeW-1:0]     press_start_new, last_click_new, pv_start_new;
  logic signed [CountW-1:0] detent, ld_base, last_detent_new;
  logic signed [CountW:0]   diff;
  logic [CountW-1:0]    diff_mag, steps_new, step_total_new;
  logic                 big;
  dir_e                 dir_new;
  logic [SlotW-1:0]     ps1, ps2, act1, shown_new;
  logic [SlotW:0]       ps_inc;
  logic                 show1, show2, show_new, committed;
  logic [TimeW-1:0]     dt_press, dt_click, dt_pv;

  // output register
  logic                 ov_q, ov_d;
  event_e               o_ev_q;
  dir_e                 o_dir_q;
  logic [CountW-1:0]    o_steps_q, o_pos_q;
  logic [SlotW-1:0]     o_pv_q, o_act_q;
  logic                 o_com_q, o_show_q;
  logic [SlotW+2:0]     o_pv_ext, o_act_ext;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= HoldRst;
      dbl_q    <= DblRst;
      divcfg_q <= DivRst;
      tmo_q    <= TmoRst;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HOLD:    hold_q   <= cfg_data_i[HoldW-1:0];
        CFG_DOUBLE:  dbl_q    <= cfg_data_i[DblW-1:0];
        CFG_DIVIDER: divcfg_q <= cfg_data_i[DivW-1:0];
        CFG_TIMEOUT: tmo_q    <= cfg_data_i[TmoW-1:0];
        default:     hold_q   <= hold_q;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_accept) state_d = ST_DIV;
      ST_DIV:    if (cnt_q == DivLast) state_d = ST_UPDATE;
      ST_UPDATE: if (upd_fire) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    load_en    = 1'b0;
    div_en     = 1'b0;
    upd_en     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        load_en    = in_valid_i;
      end
      ST_DIV:    div_en = 1'b1;
      ST_UPDATE: upd_en = ~ov_q | ~out_stall_i;
      default:   in_stall_o = 1'b1;
    endcase
  end

  assign in_accept = in_valid_i & ~in_stall_o;
  assign upd_fire  = upd_en;

  // divider step: one quotient bit per cycle
  assign mag_in = encoder_count_i[CountW-1] ? (~encoder_count_i + 1'b1) : encoder_count_i;
  assign rem_t  = {rem_q, dq_q[CountW-1]};
  assign rem_ge = rem_t >= {1'b0, div_q};

  always_comb begin
    dq_d  = dq_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    div_d = div_q;
    if (load_en) begin
      dq_d  = mag_in;
      rem_d = '0;
      cnt_d = '0;
      div_d = (divcfg_q == '0) ? DivW'(1) : divcfg_q;
    end else if (div_en) begin
      dq_d  = {dq_q[CountW-2:0], rem_ge};
      rem_d = rem_ge ? DivW'(rem_t - {1'b0, div_q}) : rem_t[DivW-1:0];
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    div_q <= div_d;
    if (load_en) begin
      neg_q     <= encoder_count_i[CountW-1];
      pressed_q <= ~button_level_i;
      now_q     <= now_ms_i;
    end
  end

  // button
  assign dt_press = now_q - press_start_q;
  assign dt_click = now_q - last_click_q;
  assign dt_pv    = now_q - pv_start_q;

  always_comb begin
    ev_new          = ev_now_q;
    press_start_new = press_start_q;
    last_click_new  = last_click_q;
    if (!pressed_q && !was_pressed_q) begin
      ev_new = EV_IDLE;
    end else if (!pressed_q) begin
      ev_new         = EV_RELEASED;
      last_click_new = now_q;
    end else if (was_pressed_q) begin
      if (dt_press > TimeW'(hold_q)) ev_new = EV_HELD;
    end else begin
      press_start_new = now_q;
      ev_new          = (dt_click < TimeW'(dbl_q)) ? EV_DOUBLE : EV_PRESSED;
      last_click_new  = now_q;
    end
  end

  // encoder
  assign detent   = neg_q ? (~dq_q + 1'b1) : dq_q;
  assign ld_base  = (div_q != div_seen_q) ? detent : last_detent_q;
  assign diff     = {ld_base[CountW-1], ld_base} - {detent[CountW-1], detent};
  assign diff_mag = diff[CountW] ? CountW'(~diff + 1'b1) : diff[CountW-1:0];
  assign big      = (diff > (CountW + 1)'(signed'(1))) ||
                    (diff < -(CountW + 1)'(signed'(1))) ||
                    ((diff != '0) && (div_q < DivFine));

  always_comb begin
    dir_new         = DIR_NONE;
    steps_new       = diff_mag;
    step_total_new  = step_total_q;
    last_detent_new = ld_base;
    if (big) begin
      if (!diff[CountW] && dir_q != DIR_DOWN) begin
        dir_new         = DIR_UP;
        step_total_new  = step_total_q + 1'b1;
        last_detent_new = detent;
      end else if (diff[CountW] && dir_q != DIR_UP) begin
        dir_new         = DIR_DOWN;
        step_total_new  = step_total_q - 1'b1;
        steps_new       = diff[CountW-1:0];
        last_detent_new = detent;
      end
    end
  end

  // slots
  assign ps_inc = {1'b0, pv_slot_q} + 1'b1;

  always_comb begin
    ps1          = pv_slot_q;
    act1         = act_slot_q;
    show1        = showing_q;
    committed    = 1'b0;
    ps2          = ps1;
    show2        = show1;
    pv_start_new = pv_start_q;
    shown_new    = shown_q;
    show_new     = show1;
    unique case (dir_new)
      DIR_UP:   ps1 = (ps_inc >= SlotCnt) ? '0 : ps_inc[SlotW-1:0];
      DIR_DOWN: ps1 = (pv_slot_q == '0) ? SlotLast : pv_slot_q - 1'b1;
      default:  ps1 = pv_slot_q;
    endcase
    if (ev_new == EV_PRESSED && ev_now_q == EV_IDLE && act_slot_q != ps1) begin
      act1      = ps1;
      show1     = 1'b0;
      committed = 1'b1;
    end
    ps2   = ps1;
    show2 = show1;
    if (dt_pv > TimeW'(tmo_q) && show1 && act1 != ps1) begin
      ps2          = act1;
      show2        = 1'b0;
      pv_start_new = now_q;
    end
    show_new = show2;
    if (shown_q != ps2) begin
      shown_new    = ps2;
      show_new     = 1'b1;
      pv_start_new = now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_pressed_q <= 1'b1;
      ev_now_q      <= EV_IDLE;
      press_start_q <= '0;
      last_click_q  <= '0;
      last_detent_q <= '0;
      dir_q         <= DIR_NONE;
      step_total_q  <= '0;
      pv_slot_q     <= '0;
      act_slot_q    <= '0;
      shown_q       <= '0;
      showing_q     <= 1'b0;
      pv_start_q    <= '0;
      div_seen_q    <= DivRst;
    end else if (upd_fire) begin
      was_pressed_q <= pressed_q;
      ev_now_q      <= ev_new;
      press_start_q <= press_start_new;
      last_click_q  <= last_click_new;
      last_detent_q <= last_detent_new;
      dir_q         <= dir_new;
      step_total_q  <= step_total_new;
      pv_slot_q     <= ps2;
      act_slot_q    <= act1;
      shown_q       <= shown_new;
      showing_q     <= show_new;
      pv_start_q    <= pv_start_new;
      div_seen_q    <= div_q;
    end
  end

  // output register
  always_comb begin
    ov_d = ov_q;
    if (upd_fire) begin
      ov_d = 1'b1;
    end else if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      o_ev_q    <= ev_new;
      o_dir_q   <= dir_new;
      o_steps_q <= steps_new;
      o_pos_q   <= step_total_new;
      o_pv_q    <= ps2;
      o_act_q   <= act1;
      o_com_q   <= committed;
      o_show_q  <= show_new;
    end
  end

  assign o_pv_ext  = {3'b000, o_pv_q};
  assign o_act_ext = {3'b000, o_act_q};

  assign out_valid_o        = ov_q;
  assign button_event_o     = o_ev_q;
  assign turn_direction_o   = o_dir_q;
  assign step_amount_o      = o_steps_q;
  assign turn_position_o    = o_pos_q;
  assign preview_slot_out_o = o_pv_ext[2:0];
  assign active_slot_out_o  = o_act_ext[2:0];
  assign slot_committed_o   = o_com_q;
  assign preview_showing_o  = o_show_q;

  // assertions
  a_commit_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && committed) |=> (o_act_q == o_pv_q))
    else $error("committed slot differs from preview");

  a_no_turn_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && dir_new == DIR_NONE) |=> (step_total_q == $past(step_total_q)))
    else $error("turn position moved without a step");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == DivLast) |=> (state_q == ST_UPDATE))
    else $error("divider did not finish after its last bit");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(o_pos_q) && $stable(o_ev_q)))
    else $error("pending result overwritten while stalled");

endmodule
